### rtl/obwl_pkg.sv
// Shared types, edge table and fixed-point helpers for the box wireframe block.
package obwl_pkg;

  localparam int EdgeCount = 12;
  localparam logic [3:0] LastEdge = 4'(EdgeCount - 1);

  typedef logic signed [31:0] coord_t;
  typedef coord_t [2:0] vec_t;

  typedef struct packed {
    vec_t [7:0]  corner;
    logic [31:0] color;
  } box_t;

  typedef struct packed {
    logic valid;
    box_t data;
  } box_push_t;

  localparam coord_t CoordMax = 32'sh7fffffff;
  localparam coord_t CoordMin = 32'sh80000000;

  function automatic coord_t sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647) begin
      return CoordMax;
    end else if (x < -36'sd2147483648) begin
      return CoordMin;
    end
    return x[31:0];
  endfunction

  function automatic coord_t neg_sat(input coord_t x);
    if (x == CoordMin) begin
      return CoordMax;
    end
    return -x;
  endfunction

  // Q2.14 x Q16.16 product back to Q16.16, round half up.
  function automatic coord_t round_prod(input logic signed [47:0] p);
    logic signed [48:0] t;
    logic signed [34:0] r;
    t = {p[47], p} + 49'sd8192;
    r = t[48:14];
    return sat32(36'(r));
  endfunction

  function automatic coord_t sub_sat(input coord_t a, input coord_t b);
    return sat32(36'(a) - 36'(b));
  endfunction

  function automatic coord_t add_sat(input coord_t a, input coord_t b);
    return sat32(36'(a) + 36'(b));
  endfunction

  function automatic logic [2:0] edge_from(input logic [3:0] e);
    case (e)
      4'd0, 4'd3, 4'd8:  return 3'd0 + ((e == 4'd3) ? 3'd2 : 3'd0);
      4'd1, 4'd9:        return 3'd1;
      4'd2, 4'd11:       return 3'd3;
      4'd4:              return 3'd4;
      4'd5:              return 3'd5;
      4'd6:              return 3'd7;
      4'd7:              return 3'd6;
      4'd10:             return 3'd2;
      default:           return 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] edge_to(input logic [3:0] e);
    case (e)
      4'd0:    return 3'd1;
      4'd1:    return 3'd3;
      4'd2:    return 3'd2;
      4'd3:    return 3'd0;
      4'd4:    return 3'd5;
      4'd5:    return 3'd7;
      4'd6:    return 3'd6;
      4'd7:    return 3'd4;
      4'd8:    return 3'd4;
      4'd9:    return 3'd5;
      4'd10:   return 3'd6;
      4'd11:   return 3'd7;
      default: return 3'd0;
    endcase
  endfunction

endpackage

### rtl/obwl_front.sv
// Front end: holds one box, issues its eight corners into the rotation pipeline.
module obwl_front import obwl_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  coord_t                        center_x,
  input  coord_t                        center_y,
  input  coord_t                        center_z,
  input  coord_t                        half_x,
  input  coord_t                        half_y,
  input  coord_t                        half_z,
  input  logic signed [15:0]            quat_w,
  input  logic signed [15:0]            quat_x,
  input  logic signed [15:0]            quat_y,
  input  logic signed [15:0]            quat_z,
  input  logic [31:0]                   color,
  input  logic [$clog2(QDEPTH+1)-1:0]   q_count,
  output box_push_t                     q_push
);

  localparam int CW = $clog2(QDEPTH + 1);
  localparam int Stages = 5;

  typedef struct packed {
    vec_t               center;
    logic signed [15:0] w;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic [31:0]        color;
  } src_t;

  typedef struct packed {
    vec_t               v;
    vec_t               center;
    logic signed [15:0] w;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic [31:0]        color;
    logic [2:0]         cidx;
  } ctx_t;

  src_t               box;
  vec_t               half;
  logic               box_valid;
  logic [2:0]         cidx;
  logic [CW-1:0]      pending;
  logic               credit_ok;
  logic               issue;
  logic               accept;
  logic               done;

  ctx_t               ctx [Stages];
  logic [Stages-1:0]  vld;
  logic signed [47:0] pa [6];
  logic signed [47:0] pb [6];
  logic signed [47:0] pw [3];
  vec_t               a;
  vec_t               s;
  vec_t               corner;
  vec_t [7:0]         asm_corner;

  assign credit_ok = (CW'(q_count) + pending) < CW'(QDEPTH);
  assign issue     = box_valid && ((cidx != 3'd0) || credit_ok);
  assign done      = issue && (cidx == 3'd7);
  assign full      = box_valid && !done;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
      cidx      <= 3'd0;
      pending   <= '0;
    end else begin
      if (accept) begin
        box_valid <= 1'b1;
      end else if (done) begin
        box_valid <= 1'b0;
      end
      if (issue) begin
        cidx <= cidx + 3'd1;
      end
      case ({issue && (cidx == 3'd0), q_push.valid})
        2'b10:   pending <= pending + CW'(1);
        2'b01:   pending <= pending - CW'(1);
        default: pending <= pending;
      endcase
    end
    if (accept) begin
      box.center <= {center_z, center_y, center_x};
      half       <= {half_z, half_y, half_x};
      box.w      <= quat_w;
      box.ux     <= quat_x;
      box.uy     <= quat_y;
      box.uz     <= quat_z;
      box.color  <= color;
    end
  end

  // Pipeline valid bits; the queue credit keeps the pipe from ever stalling.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Stages-2:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    ctx[0].center <= box.center;
    ctx[0].w      <= box.w;
    ctx[0].ux     <= box.ux;
    ctx[0].uy     <= box.uy;
    ctx[0].uz     <= box.uz;
    ctx[0].color  <= box.color;
    ctx[0].cidx   <= cidx;
    for (int k = 0; k < 3; k++) begin
      ctx[0].v[k] <= cidx[k] ? half[k] : neg_sat(half[k]);
    end
    for (int i = 1; i < Stages; i++) begin
      ctx[i] <= ctx[i-1];
    end

    // u x v products
    pa[0] <= ctx[0].uy * ctx[0].v[2];
    pa[1] <= ctx[0].uz * ctx[0].v[1];
    pa[2] <= ctx[0].uz * ctx[0].v[0];
    pa[3] <= ctx[0].ux * ctx[0].v[2];
    pa[4] <= ctx[0].ux * ctx[0].v[1];
    pa[5] <= ctx[0].uy * ctx[0].v[0];

    a[0] <= sub_sat(round_prod(pa[0]), round_prod(pa[1]));
    a[1] <= sub_sat(round_prod(pa[2]), round_prod(pa[3]));
    a[2] <= sub_sat(round_prod(pa[4]), round_prod(pa[5]));

    // u x a and w * a products
    pb[0] <= ctx[2].uy * a[2];
    pb[1] <= ctx[2].uz * a[1];
    pb[2] <= ctx[2].uz * a[0];
    pb[3] <= ctx[2].ux * a[2];
    pb[4] <= ctx[2].ux * a[1];
    pb[5] <= ctx[2].uy * a[0];
    for (int k = 0; k < 3; k++) begin
      pw[k] <= ctx[2].w * a[k];
    end

    for (int k = 0; k < 3; k++) begin
      s[k] <= add_sat(round_prod(pw[k]),
                      sub_sat(round_prod(pb[2*k]), round_prod(pb[2*k+1])));
    end

    for (int k = 0; k < 3; k++) begin
      corner[k] <= add_sat(ctx[4].center[k], add_sat(ctx[4].v[k], add_sat(s[k], s[k])));
    end
  end

  // Collect corners; the eighth one completes the box beat.
  logic [2:0]  out_cidx;
  logic [31:0] out_color;
  logic        out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[Stages-1];
    end
    out_cidx  <= ctx[Stages-1].cidx;
    out_color <= ctx[Stages-1].color;
    if (out_vld) begin
      asm_corner[out_cidx] <= corner;
    end
  end

  always_comb begin
    q_push.valid       = out_vld && (out_cidx == 3'd7);
    q_push.data.corner = asm_corner;
    q_push.data.corner[7] = corner;
    q_push.data.color  = out_color;
  end

endmodule

### rtl/obwl_queue.sv
// Short queue of finished boxes between the corner pipeline and the line emitter.
module obwl_queue import obwl_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  box_push_t                    q_push,
  input  logic                         q_pop,
  output box_t                         head,
  output logic [$clog2(QDEPTH+1)-1:0]  count
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  box_t          mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({q_push.valid, q_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
    if (q_push.valid) begin
      mem[wr_ptr] <= q_push.data;
    end
  end

endmodule

### rtl/obwl_back.sv
// Back end: walks the edges of the head box, index 0 through LastEdge, into the output register.
module obwl_back import obwl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  box_t        head,
  input  logic        head_valid,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output coord_t      start_x,
  output coord_t      start_y,
  output coord_t      start_z,
  output coord_t      end_x,
  output coord_t      end_y,
  output coord_t      end_z,
  output logic [31:0] line_color,
  output logic [3:0]  edge_index,
  output logic        last
);

  logic       out_valid;
  logic [3:0] ecnt;
  logic       advance;
  vec_t       p0;
  vec_t       p1;

  assign empty   = !out_valid;
  assign advance = head_valid && (!out_valid || pop);
  assign q_pop   = advance && (ecnt == LastEdge);
  assign p0      = head.corner[edge_from(ecnt)];
  assign p1      = head.corner[edge_to(ecnt)];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ecnt      <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        ecnt      <= (ecnt == LastEdge) ? 4'd0 : ecnt + 4'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      start_x    <= p0[0];
      start_y    <= p0[1];
      start_z    <= p0[2];
      end_x      <= p1[0];
      end_y      <= p1[1];
      end_z      <= p1[2];
      line_color <= head.color;
      edge_index <= ecnt;
      last       <= (ecnt == LastEdge);
    end
  end

endmodule

### rtl/oriented_box_wireframe_lines.sv
// A new box is taken while earlier ones still drain through the queue and output.
// Throughput: one line per box edge, one line per cycle through the single output
// register while a box is queued and pop keeps up; first corners wait for credit.
// Corners run one per cycle through a six-stage multiply/round/saturate pipe.
// Reset (synchronous, active high) empties the queue and the output; no sweep.
module oriented_box_wireframe_lines import obwl_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  coord_t             center_x,
  input  coord_t             center_y,
  input  coord_t             center_z,
  input  coord_t             half_x,
  input  coord_t             half_y,
  input  coord_t             half_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic [31:0]        color,
  output logic               empty,
  input  logic               pop,
  output coord_t             start_x,
  output coord_t             start_y,
  output coord_t             start_z,
  output coord_t             end_x,
  output coord_t             end_y,
  output coord_t             end_z,
  output logic [31:0]        line_color,
  output logic [3:0]         edge_index,
  output logic               last
);

  box_push_t                        q_push;
  box_t                             head;
  logic [$clog2(QDEPTH+1)-1:0]      q_count;
  logic                             q_pop;

  obwl_front #(.QDEPTH(QDEPTH)) u_front (
    .clk, .rst, .push, .full,
    .center_x, .center_y, .center_z,
    .half_x, .half_y, .half_z,
    .quat_w, .quat_x, .quat_y, .quat_z,
    .color, .q_count, .q_push
  );

  obwl_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk, .rst, .q_push, .q_pop, .head, .count(q_count)
  );

  obwl_back u_back (
    .clk, .rst, .head, .head_valid(q_count != '0), .q_pop,
    .pop, .empty,
    .start_x, .start_y, .start_z, .end_x, .end_y, .end_z,
    .line_color, .edge_index, .last
  );

endmodule

### rtl/obwl_checker.sv
// Port-level checks on the line stream, bound to the top level.
module obwl_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [31:0] start_x,
  input logic [3:0]  edge_index,
  input logic        last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (edge_index == 4'd11)))
    else $error("last flag does not match edge index");

  a_edge_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> (!empty && edge_index == $past(edge_index) + 4'd1))
    else $error("edge sequence broken within a box");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(start_x) && $stable(edge_index)))
    else $error("stalled line beat changed");

endmodule

bind oriented_box_wireframe_lines obwl_checker u_obwl_checker (.*);
